@@ rtl/core/ksel_pkg.sv @@
package ksel_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANK_BAD = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // store the transferred element
    logic clear;      // start a new vector
    logic start_sel;  // restart the candidate index
    logic rd_cand;    // read the candidate entry
    logic cap_cand;   // capture the candidate and restart the scan
    logic rd_scan;    // read the next scan entry
    logic next_cand;  // advance to the next candidate
    logic res_load;   // load the result register
  } ksel_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic overflowed;
    logic rank_bad;
    logic last_scan;
    logic found;
  } ksel_stat_t;

  // Map a single-precision pattern to a key whose unsigned order is the
  // numeric order, with -0 below +0.
  function automatic logic [31:0] order_key(input logic [31:0] bits);
    logic [31:0] key;
    if (bits[31]) begin
      key = ~bits;
    end else begin
      key = bits ^ 32'h8000_0000;
    end
    return key;
  endfunction

endpackage

@@ rtl/core/ksel_if.sv @@
// Input element channel.
interface ksel_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  logic [7:0]  rank;
  logic        final_req;

  modport source (output valid, value_bits, rank, final_req, input ready);
  modport sink (input valid, value_bits, rank, final_req, output ready);
endinterface

// Result channel.
interface ksel_out_if;
  logic             valid;
  logic             ready;
  logic [31:0]      selected_bits;
  ksel_pkg::status_t status;

  modport source (output valid, selected_bits, status, input ready);
  modport sink (input valid, selected_bits, status, output ready);
endinterface

@@ rtl/core/ksel_datapath.sv @@
module ksel_datapath #(
  parameter int MAX_ELEMENTS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ksel_pkg::ksel_cmd_t cmd,
  input  logic [31:0]         value_bits,
  input  logic [7:0]          rank,
  input  logic                final_req,
  output ksel_pkg::ksel_stat_t stat,
  output logic [31:0]         res_bits,
  output ksel_pkg::status_t   res_status
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int KW = (CW > 8) ? CW : 8;

  logic [31:0]   mem [MAX_ELEMENTS];
  logic [CW-1:0] count_r;
  logic          ovf_r;
  logic [7:0]    k_r;
  logic [AW-1:0] i_r;
  logic [AW-1:0] j_r;
  logic [31:0]   rd_data_r;
  logic          acc_v_r;
  logic [31:0]   cand_bits_r;
  logic [31:0]   cand_key_r;
  logic [CW-1:0] below_r;
  logic [CW-1:0] upto_r;
  logic [31:0]   res_bits_r;
  ksel_pkg::status_t res_status_r;

  logic [31:0]   scan_key;
  logic [KW-1:0] k_ext;
  logic          full;

  assign scan_key = ksel_pkg::order_key(rd_data_r);
  assign k_ext    = KW'(k_r);
  assign full     = (count_r == CW'(MAX_ELEMENTS));

  // Element store: one write on load, one registered read.
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[count_r[AW-1:0]] <= value_bits;
    end
    if (cmd.rd_cand) begin
      rd_data_r <= mem[i_r];
    end else if (cmd.rd_scan) begin
      rd_data_r <= mem[j_r];
    end
  end

  // Fill count, overflow flag and the latched rank.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.clear) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && final_req) begin
      k_r <= rank;
    end
  end

  // Candidate and scan indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r     <= '0;
      j_r     <= '0;
      acc_v_r <= 1'b0;
    end else begin
      acc_v_r <= cmd.rd_scan;
      if (cmd.start_sel) begin
        i_r <= '0;
      end else if (cmd.next_cand) begin
        i_r <= i_r + AW'(1);
      end
      if (cmd.cap_cand) begin
        j_r <= '0;
      end else if (cmd.rd_scan) begin
        j_r <= j_r + AW'(1);
      end
    end
  end

  // Rank counting of the candidate against every stored element.
  always_ff @(posedge clk) begin
    if (cmd.cap_cand) begin
      cand_bits_r <= rd_data_r;
      cand_key_r  <= ksel_pkg::order_key(rd_data_r);
      below_r     <= '0;
      upto_r      <= '0;
    end else if (acc_v_r) begin
      below_r <= below_r + CW'(scan_key < cand_key_r);
      upto_r  <= upto_r + CW'(scan_key <= cand_key_r);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (ovf_r) begin
        res_bits_r   <= '0;
        res_status_r <= ksel_pkg::STATUS_OVERFLOW;
      end else if (stat.rank_bad) begin
        res_bits_r   <= '0;
        res_status_r <= ksel_pkg::STATUS_RANK_BAD;
      end else begin
        res_bits_r   <= cand_bits_r;
        res_status_r <= ksel_pkg::STATUS_OK;
      end
    end
  end

  assign stat.overflowed = ovf_r;
  assign stat.rank_bad   = (k_ext >= KW'(count_r));
  assign stat.last_scan  = (j_r == AW'(count_r - CW'(1)));
  assign stat.found      = (KW'(below_r) <= k_ext) && (k_ext < KW'(upto_r));
  assign res_bits        = res_bits_r;
  assign res_status      = res_status_r;

endmodule

@@ rtl/core/ksel_ctrl.sv @@
module ksel_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_final,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ksel_pkg::ksel_stat_t stat,
  output ksel_pkg::ksel_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_RD_CAND, S_CAP_CAND, S_SCAN, S_DRAIN, S_CHECK, S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_xfer;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_xfer   = in_valid && in_ready;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_xfer;
        if (in_xfer && in_final) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.overflowed || stat.rank_bad) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.start_sel = 1'b1;
          state_nxt     = S_RD_CAND;
        end
      end
      S_RD_CAND: begin
        cmd.rd_cand = 1'b1;
        state_nxt   = S_CAP_CAND;
      end
      S_CAP_CAND: begin
        cmd.cap_cand = 1'b1;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_scan = 1'b1;
        if (stat.last_scan) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.found) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.next_cand = 1'b1;
          state_nxt     = S_RD_CAND;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/kth_smallest_select_f32_core.sv @@
// K-th smallest selection over a streamed vector of single-precision values.
// The in_if channel takes one element per transfer; the element with
// final_req set closes the vector and carries the 0-based rank. The out_if
// channel gives one result per vector: the element at that rank in ascending
// numeric order (-0 below +0), with status OK, or 0 with status RANK_BAD
// when the rank is not below the element count, or OVERFLOW when more than
// MAX_ELEMENTS elements arrived (those extra elements are dropped).
// Non-final elements are taken one per cycle and give no result.
// After the final element the block stops taking input and searches: each
// candidate entry of a vector of n elements is read, captured, compared
// against all n stored entries through the single read port of the element
// store and then checked; the first candidate whose rank range holds the
// rank gives the result. Error results are loaded without any search.
// The result waits in its register until out_if.ready; input stays blocked
// until that transfer, after which a new vector starts. Reset empties the
// vector and drops any pending result; no clearing pass is needed.
module kth_smallest_select_f32_core #(
  parameter int MAX_ELEMENTS = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  ksel_in_if.sink       in_if,
  ksel_out_if.source    out_if
);

  ksel_pkg::ksel_cmd_t  cmd;
  ksel_pkg::ksel_stat_t stat;

  // Sequencer.
  ksel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_final  (in_if.final_req),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Store, counters and result register.
  ksel_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .value_bits (in_if.value_bits),
    .rank       (in_if.rank),
    .final_req  (in_if.final_req),
    .stat       (stat),
    .res_bits   (out_if.selected_bits),
    .res_status (out_if.status)
  );

endmodule

@@ rtl/core/ksel_checker.sv @@
module ksel_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] selected_bits,
  input logic [1:0]  status
);

  // A pending result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(selected_bits) && $stable(status))
    else $error("result dropped or changed while stalled");

  // No element is taken while a result waits.
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // Error results carry zero.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ksel_pkg::STATUS_OK) |-> selected_bits == 32'd0)
    else $error("error result with nonzero value");

  // Only defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == ksel_pkg::STATUS_OK) || (status == ksel_pkg::STATUS_RANK_BAD)
      || (status == ksel_pkg::STATUS_OVERFLOW))
    else $error("undefined status code");

  // After a result transfer the block takes input again.
  a_resume: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("block did not return to input");

endmodule

bind kth_smallest_select_f32_core ksel_checker u_ksel_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .selected_bits (out_if.selected_bits),
  .status        (out_if.status)
);

@@ verif/ksel_select_checker.sv @@
module ksel_select_checker (
  input  logic  clk,
  input  logic  rst_n,
  ksel_in_if    in_mon,
  ksel_out_if   out_mon,
  output int    mismatch_count,
  output int    results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 256;

  typedef struct {
    logic [31:0]       selected_bits;
    ksel_pkg::status_t status;
  } selection_t;

  logic [31:0] vector_store[$];
  logic        vector_overflowed;
  selection_t  selection_queue[$];

  // Sortable key of a single-precision pattern; -0 ranks below +0.
  function automatic logic [31:0] sort_key(input logic [31:0] bits);
    return bits[31] ? ~bits : (bits ^ 32'h8000_0000);
  endfunction

  // Element of the stored vector that sits at sorted position k.
  function automatic logic [31:0] element_at_rank(input int k);
    int below;
    int upto;
    logic [31:0] cand_key;
    for (int i = 0; i < vector_store.size(); i++) begin
      below = 0;
      upto = 0;
      cand_key = sort_key(vector_store[i]);
      foreach (vector_store[j]) begin
        if (sort_key(vector_store[j]) < cand_key) below++;
        if (sort_key(vector_store[j]) <= cand_key) upto++;
      end
      if (below <= k && k < upto) return vector_store[i];
    end
    return 32'h0;
  endfunction

  // Track the input transfers and score the result transfers.
  always @(posedge clk) begin
    selection_t sel;
    selection_t exp_sel;
    int errs;
    errs = 0;
    if (!rst_n) begin
      vector_store.delete();
      vector_overflowed = 1'b0;
      selection_queue.delete();
      mismatch_count <= 0;
      results_pending <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (vector_store.size() < CAPACITY) begin
          vector_store.push_back(in_mon.value_bits);
        end else begin
          vector_overflowed = 1'b1;
        end
        if (in_mon.final_req) begin
          if (vector_overflowed) begin
            sel.selected_bits = 32'h0;
            sel.status = ksel_pkg::STATUS_OVERFLOW;
          end else if (int'(in_mon.rank) >= vector_store.size()) begin
            sel.selected_bits = 32'h0;
            sel.status = ksel_pkg::STATUS_RANK_BAD;
          end else begin
            sel.selected_bits = element_at_rank(int'(in_mon.rank));
            sel.status = ksel_pkg::STATUS_OK;
          end
          selection_queue.push_back(sel);
          vector_store.delete();
          vector_overflowed = 1'b0;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (selection_queue.size() == 0) begin
          $display("%0t: unexpected result transfer bits=%h status=%0d", $time,
                   out_mon.selected_bits, out_mon.status);
          errs++;
        end else begin
          exp_sel = selection_queue.pop_front();
          if (out_mon.selected_bits !== exp_sel.selected_bits) begin
            $display("%0t: selected_bits expected %h actual %h", $time,
                     exp_sel.selected_bits, out_mon.selected_bits);
            errs++;
          end
          if (out_mon.status !== exp_sel.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_sel.status, out_mon.status);
            errs++;
          end
        end
      end
      mismatch_count <= mismatch_count + errs;
      results_pending <= selection_queue.size();
    end
  end

endmodule

@@ verif/tb_kth_smallest_select_f32_core.sv @@
module tb_kth_smallest_select_f32_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 380;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   mismatch_count;
  int   results_pending;
  int   cycle_count = 0;
  logic hold_request = 1'b0;
  logic hold_issued = 1'b0;
  logic no_idle = 1'b0;
  int   items_sent = 0;

  ksel_in_if  in_ch ();
  ksel_out_if out_ch ();

  kth_smallest_select_f32_core #(.MAX_ELEMENTS(256)) DUT (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  ksel_select_checker scoreboard (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .mismatch_count(mismatch_count), .results_pending(results_pending)
  );

  always #10 clk = ~clk;

  // Global timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Random element value: special patterns, a small tie-prone set, or any bits.
  function automatic logic [31:0] pick_value();
    logic [31:0] specials[10] = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000,
                                  32'hff80_0000, 32'h7fff_ffff, 32'hffff_ffff,
                                  32'h0000_0001, 32'h8000_0001, 32'h3f80_0000,
                                  32'hbf80_0000};
    case ($urandom_range(0, 3))
      0: return specials[$urandom_range(0, 9)];
      1: return {$urandom_range(0, 1) == 1, 8'd127, 20'd0, 3'($urandom_range(0, 7))};
      default: return $urandom;
    endcase
  endfunction

  // Offer one element and wait for its transfer; valid stays high between
  // back-to-back elements.
  task automatic send_element(input logic [31:0] value, input logic [7:0] k,
                              input logic fin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.value_bits = value;
    in_ch.rank = k;
    in_ch.final_req = fin;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Send a whole vector with random content and the given rank.
  task automatic send_vector(input int n, input logic [7:0] k);
    for (int i = 0; i < n; i++) send_element(pick_value(), k, i == n - 1);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_request = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Stimulus and verdict.
  initial begin
    int n;
    int k;
    int target;
    in_ch.valid = 1'b0;
    in_ch.value_bits = '0;
    in_ch.rank = '0;
    in_ch.final_req = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: single element, bad rank, signed zeros, infinities, NaNs, ties.
    send_element(32'h3f80_0000, 8'd0, 1'b1);
    send_element(32'h0000_0000, 8'd1, 1'b1);
    send_element(32'h0000_0000, 8'd0, 1'b0);
    send_element(32'h8000_0000, 8'd0, 1'b1);
    send_element(32'h0000_0000, 8'd0, 1'b0);
    send_element(32'h8000_0000, 8'd1, 1'b1);
    send_element(32'h7f80_0000, 8'd0, 1'b0);
    send_element(32'hff80_0000, 8'd0, 1'b0);
    send_element(32'h7fff_ffff, 8'd0, 1'b0);
    send_element(32'hffff_ffff, 8'd3, 1'b1);
    send_element(32'h0000_0001, 8'd0, 1'b0);
    send_element(32'h8000_0001, 8'd0, 1'b0);
    send_element(32'h0000_0001, 8'd0, 1'b0);
    send_element(32'h0000_0001, 8'd2, 1'b1);
    send_element(32'h4000_0000, 8'd255, 1'b1);
    send_element(32'hc000_0000, 8'd0, 1'b0);
    send_element(32'hc000_0000, 8'd1, 1'b1);
    drain();

    // Full capacity with the top rank, then an overflow vector.
    no_idle = 1'b1;
    send_vector(256, 8'd255);
    send_vector(257, 8'd0);
    no_idle = 1'b0;
    drain();

    // Random vectors, mostly small with in-range ranks.
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, n - 1);
      no_idle = ($urandom_range(0, 7) == 0);
      if (!hold_issued && items_sent > target - RANDOM_ITEMS / 2) begin
        hold_request = 1'b1;
        hold_issued = 1'b1;
      end
      if ($urandom_range(0, 29) == 0) drain();
      send_vector(n, 8'(k));
    end
    no_idle = 1'b0;
    drain();
    repeat (50) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
